// File: rtl/core/ptdt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ptdt_pkg;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 16;
   localparam int PIX_W      = 12;
   localparam int GAIN_W     = 16;
   localparam int ANGLE_W    = 8;
   localparam int COUNT_W    = 16;
   localparam int STEP_W     = 2;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_DEAD_ZONE     = 3'd0,
      CSR_PAN_GAIN      = 3'd1,
      CSR_TILT_GAIN     = 3'd2,
      CSR_ANGLE_MIN     = 3'd3,
      CSR_ANGLE_MAX     = 3'd4,
      CSR_CENTER_X      = 3'd5,
      CSR_CENTER_Y      = 3'd6,
      CSR_SEND_INTERVAL = 3'd7
   } csr_index_type;

   typedef enum logic {
      CMD_TICK   = 1'b0,
      CMD_TARGET = 1'b1
   } command_type;

   localparam logic [PIX_W-1:0]   RST_DEAD_ZONE     = 12'd30;
   localparam logic [GAIN_W-1:0]  RST_PAN_GAIN      = 16'd1966;
   localparam logic [GAIN_W-1:0]  RST_TILT_GAIN     = 16'd1966;
   localparam logic [ANGLE_W-1:0] RST_ANGLE_MIN     = 8'd45;
   localparam logic [ANGLE_W-1:0] RST_ANGLE_MAX     = 8'd135;
   localparam logic [PIX_W-1:0]   RST_CENTER_X      = 12'd640;
   localparam logic [PIX_W-1:0]   RST_CENTER_Y      = 12'd360;
   localparam logic [COUNT_W-1:0] RST_SEND_INTERVAL = 16'd33;

   localparam logic [ANGLE_W-1:0] ANGLE_HOME = 8'd90;
   localparam logic [STEP_W-1:0]  STEP_LIMIT = 2'd3;
   localparam logic [COUNT_W-1:0] COUNT_MAX  = '1;

   typedef struct packed {
      logic [PIX_W-1:0]   dead_zone;
      logic [GAIN_W-1:0]  pan_gain;
      logic [GAIN_W-1:0]  tilt_gain;
      logic [ANGLE_W-1:0] angle_min;
      logic [ANGLE_W-1:0] angle_max;
      logic [PIX_W-1:0]   center_x;
      logic [PIX_W-1:0]   center_y;
      logic [COUNT_W-1:0] send_interval;
   } cfg_type;

endpackage

`default_nettype wire

// File: rtl/core/ptdt_cfg.sv
`timescale 1ns / 1ps
`default_nettype none

module ptdt_cfg (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               csr_we,
   input  wire logic [ptdt_pkg::CSR_ADDR_W-1:0]    csr_addr,
   input  wire logic [ptdt_pkg::CSR_DATA_W-1:0]    csr_wdata,
   output ptdt_pkg::cfg_type                       cfg
);
   import ptdt_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index_type'(csr_addr))
            CSR_DEAD_ZONE:     cfg_in.dead_zone     = csr_wdata[PIX_W-1:0];
            CSR_PAN_GAIN:      cfg_in.pan_gain      = csr_wdata[GAIN_W-1:0];
            CSR_TILT_GAIN:     cfg_in.tilt_gain     = csr_wdata[GAIN_W-1:0];
            CSR_ANGLE_MIN:     cfg_in.angle_min     = csr_wdata[ANGLE_W-1:0];
            CSR_ANGLE_MAX:     cfg_in.angle_max     = csr_wdata[ANGLE_W-1:0];
            CSR_CENTER_X:      cfg_in.center_x      = csr_wdata[PIX_W-1:0];
            CSR_CENTER_Y:      cfg_in.center_y      = csr_wdata[PIX_W-1:0];
            CSR_SEND_INTERVAL: cfg_in.send_interval = csr_wdata[COUNT_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.dead_zone     <= RST_DEAD_ZONE;
         cfg_ff.pan_gain      <= RST_PAN_GAIN;
         cfg_ff.tilt_gain     <= RST_TILT_GAIN;
         cfg_ff.angle_min     <= RST_ANGLE_MIN;
         cfg_ff.angle_max     <= RST_ANGLE_MAX;
         cfg_ff.center_x      <= RST_CENTER_X;
         cfg_ff.center_y      <= RST_CENTER_Y;
         cfg_ff.send_interval <= RST_SEND_INTERVAL;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

// File: rtl/core/ptdt_axis.sv
`timescale 1ns / 1ps
`default_nettype none

module ptdt_axis (
   input  wire logic [ptdt_pkg::PIX_W-1:0]         pos,
   input  wire logic [ptdt_pkg::PIX_W-1:0]         centre,
   input  wire logic [ptdt_pkg::GAIN_W-1:0]        gain,
   input  wire logic [ptdt_pkg::PIX_W-1:0]         dead_zone,
   output logic signed [ptdt_pkg::STEP_W:0]        change
);
   import ptdt_pkg::*;

   localparam int PROD_W = GAIN_W + PIX_W;

   logic signed [PIX_W:0]  err;
   logic signed [PIX_W:0]  err_abs;
   logic [PIX_W-1:0]       mag;
   logic [PROD_W-1:0]      prod;
   logic [PIX_W-1:0]       step_raw;
   logic [STEP_W-1:0]      step;
   logic signed [STEP_W:0] step_s;

   always_comb begin
      err      = $signed({1'b0, pos}) - $signed({1'b0, centre});
      err_abs  = err[PIX_W] ? -err : err;
      mag      = err_abs[PIX_W-1:0];
      prod     = gain * mag;
      step_raw = prod[PROD_W-1:GAIN_W];
      step     = (step_raw > PIX_W'(STEP_LIMIT)) ? STEP_LIMIT : step_raw[STEP_W-1:0];
      step_s   = $signed({1'b0, step});
      if (mag <= dead_zone) begin
         change = '0;
      end else if (err[PIX_W]) begin
         change = -step_s;
      end else begin
         change = step_s;
      end
   end

endmodule

`default_nettype wire

// File: rtl/core/pan_tilt_deadband_tracker_core.sv
// Two-axis pan/tilt tracker with dead zone, step limit, slew and send pacing.
//
// Input channel (req_*): one item per cycle while req_stall is low. command 0
// is a one millisecond tick that advances the saturating send timer; command 1
// carries a face centre that moves the pan and tilt angles.
// Result channel (rsp_*): one pan/tilt command, only from a target item that
// emits. Ticks and non-emitting target items give no result.
// Config port (csr_*): one register per write, taken at once; write only
// while no item is in flight.
// An item in the input register updates the state when it advances; its result
// goes into the result register. Throughput is one item per cycle while the
// result is not stalled, set by the single state update between the registers.
// Reset clears both valid flags; angles at 90, timer saturated, nothing sent.
// A stalled result holds; the input register still takes one more item, and
// req_stall rises only while both the input and result registers are full.
`timescale 1ns / 1ps
`default_nettype none

module pan_tilt_deadband_tracker_core (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_stall,
   input  wire logic                               req_command,
   input  wire logic [ptdt_pkg::PIX_W-1:0]         req_face_x,
   input  wire logic [ptdt_pkg::PIX_W-1:0]         req_face_y,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_stall,
   output logic [ptdt_pkg::ANGLE_W-1:0]            rsp_pan_out,
   output logic [ptdt_pkg::ANGLE_W-1:0]            rsp_tilt_out,
   input  wire logic                               csr_we,
   input  wire logic [ptdt_pkg::CSR_ADDR_W-1:0]    csr_addr,
   input  wire logic [ptdt_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import ptdt_pkg::*;

   localparam int SUM_W = ANGLE_W + 2;

   function automatic logic signed [SUM_W-1:0] clamp_s(
      input logic signed [SUM_W-1:0] v,
      input logic signed [SUM_W-1:0] lo,
      input logic signed [SUM_W-1:0] hi
   );
      logic signed [SUM_W-1:0] r;
      r = v;
      if (r < lo) r = lo;
      if (r > hi) r = hi;
      return r;
   endfunction

   cfg_type cfg;

   logic               s1_valid_ff, s1_valid_in;
   command_type        s1_cmd_ff;
   logic [PIX_W-1:0]   s1_fx_ff, s1_fy_ff;

   logic [ANGLE_W-1:0] pan_ff, pan_in, tilt_ff, tilt_in;
   logic [ANGLE_W-1:0] last_pan_ff, last_pan_in, last_tilt_ff, last_tilt_in;
   logic               sent_once_ff, sent_once_in;
   logic [COUNT_W-1:0] elapsed_ff, elapsed_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [ANGLE_W-1:0] rsp_pan_ff, rsp_tilt_ff;

   logic signed [STEP_W:0]  pan_change, tilt_change;
   logic signed [SUM_W-1:0] pan_sum, tilt_sum, lo_s, hi_s;
   logic signed [SUM_W-1:0] pan_lim, tilt_lim, pan_slew, tilt_slew;
   logic signed [SUM_W-1:0] last_pan_s, last_tilt_s;
   logic                    req_take, advance, emit;

   ptdt_cfg u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   ptdt_axis u_pan_axis (
      .pos       (s1_fx_ff),
      .centre    (cfg.center_x),
      .gain      (cfg.pan_gain),
      .dead_zone (cfg.dead_zone),
      .change    (pan_change)
   );

   ptdt_axis u_tilt_axis (
      .pos       (s1_fy_ff),
      .centre    (cfg.center_y),
      .gain      (cfg.tilt_gain),
      .dead_zone (cfg.dead_zone),
      .change    (tilt_change)
   );

   assign advance   = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = s1_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      lo_s        = $signed({2'b00, cfg.angle_min});
      hi_s        = $signed({2'b00, cfg.angle_max});
      last_pan_s  = $signed({2'b00, last_pan_ff});
      last_tilt_s = $signed({2'b00, last_tilt_ff});
      pan_sum     = $signed({2'b00, pan_ff}) + SUM_W'(pan_change);
      tilt_sum    = $signed({2'b00, tilt_ff}) - SUM_W'(tilt_change);
      pan_lim     = clamp_s(pan_sum, lo_s, hi_s);
      tilt_lim    = clamp_s(tilt_sum, lo_s, hi_s);
      pan_slew    = clamp_s(pan_lim, last_pan_s - SUM_W'(1), last_pan_s + SUM_W'(1));
      tilt_slew   = clamp_s(tilt_lim, last_tilt_s - SUM_W'(1), last_tilt_s + SUM_W'(1));
      emit        = (s1_cmd_ff == CMD_TARGET)
                    && ((pan_lim[ANGLE_W-1:0] != last_pan_ff)
                        || (tilt_lim[ANGLE_W-1:0] != last_tilt_ff) || !sent_once_ff)
                    && (elapsed_ff >= cfg.send_interval);
   end

   always_comb begin
      pan_in       = pan_ff;
      tilt_in      = tilt_ff;
      last_pan_in  = last_pan_ff;
      last_tilt_in = last_tilt_ff;
      sent_once_in = sent_once_ff;
      elapsed_in   = elapsed_ff;
      if (advance) begin
         case (s1_cmd_ff)
            CMD_TICK: begin
               if (elapsed_ff != COUNT_MAX) elapsed_in = elapsed_ff + COUNT_W'(1);
            end
            CMD_TARGET: begin
               if (emit) begin
                  pan_in       = pan_slew[ANGLE_W-1:0];
                  tilt_in      = tilt_slew[ANGLE_W-1:0];
                  last_pan_in  = pan_slew[ANGLE_W-1:0];
                  last_tilt_in = tilt_slew[ANGLE_W-1:0];
                  sent_once_in = 1'b1;
                  elapsed_in   = '0;
               end else begin
                  pan_in  = pan_lim[ANGLE_W-1:0];
                  tilt_in = tilt_lim[ANGLE_W-1:0];
               end
            end
            default: ;
         endcase
      end
   end

   always_comb begin
      if (req_take) begin
         s1_valid_in = 1'b1;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
      if (advance && emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_stall) begin
         rsp_valid_in = rsp_valid_ff;
      end else begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         pan_ff       <= ANGLE_HOME;
         tilt_ff      <= ANGLE_HOME;
         last_pan_ff  <= ANGLE_HOME;
         last_tilt_ff <= ANGLE_HOME;
         sent_once_ff <= 1'b0;
         elapsed_ff   <= COUNT_MAX;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         pan_ff       <= pan_in;
         tilt_ff      <= tilt_in;
         last_pan_ff  <= last_pan_in;
         last_tilt_ff <= last_tilt_in;
         sent_once_ff <= sent_once_in;
         elapsed_ff   <= elapsed_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_cmd_ff <= command_type'(req_command);
         s1_fx_ff  <= req_face_x;
         s1_fy_ff  <= req_face_y;
      end
      if (advance && emit) begin
         rsp_pan_ff  <= pan_slew[ANGLE_W-1:0];
         rsp_tilt_ff <= tilt_slew[ANGLE_W-1:0];
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_pan_out  = rsp_pan_ff;
   assign rsp_tilt_out = rsp_tilt_ff;

   a_rsp_matches_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_pan_ff == last_pan_ff) && (rsp_tilt_ff == last_tilt_ff))
      else $error("pending item differs from last sent angles");

   a_emit_clears_timer: assert property (@(posedge clock) disable iff (reset)
      advance && emit |=> (elapsed_ff == '0) && sent_once_ff)
      else $error("timer not cleared on send");

   a_emit_keeps_angle: assert property (@(posedge clock) disable iff (reset)
      advance && emit |=> (pan_ff == last_pan_ff) && (tilt_ff == last_tilt_ff))
      else $error("slewed angle not kept after send");

   a_stall_needs_item: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> s1_valid_ff && rsp_valid_ff)
      else $error("input stalled without a full pipeline");

endmodule

`default_nettype wire

// File: sim/tb_pan_tilt_deadband_tracker_core.sv
`timescale 1ns / 1ps

module tb_pan_tilt_deadband_tracker_core;
   import ptdt_pkg::*;

   typedef struct packed {
      command_type        cmd;
      logic [PIX_W-1:0]   fx;
      logic [PIX_W-1:0]   fy;
   } track_item_t;

   typedef struct {
      logic [ANGLE_W-1:0] pan;
      logic [ANGLE_W-1:0] tilt;
      longint             cyc;
   } servo_cmd_t;

   typedef enum int {
      STALL_NONE,
      STALL_LIGHT,
      STALL_HEAVY,
      STALL_PERIODIC
   } stall_pattern_t;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic                   req_command = 1'b0;
   logic [PIX_W-1:0]       req_face_x = '0;
   logic [PIX_W-1:0]       req_face_y = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic [ANGLE_W-1:0]     rsp_pan_out;
   logic [ANGLE_W-1:0]     rsp_tilt_out;
   logic                   csr_we = 1'b0;
   logic [CSR_ADDR_W-1:0]  csr_addr = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   track_item_t   req_queue[$];
   servo_cmd_t    owed_cmds[$];
   longint        cycle_count = 0;
   int            mismatch_count = 0;

   // tracker state as predicted
   cfg_type       t_cfg;
   int            t_pan, t_tilt, t_last_pan, t_last_tilt;
   bit            t_sent;
   int            t_elapsed;

   pan_tilt_deadband_tracker_core u_top (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_command  (req_command),
      .req_face_x   (req_face_x),
      .req_face_y   (req_face_y),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_pan_out  (rsp_pan_out),
      .rsp_tilt_out (rsp_tilt_out),
      .csr_we       (csr_we),
      .csr_addr     (csr_addr),
      .csr_wdata    (csr_wdata)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   always @(posedge clock) cycle_count <= cycle_count + 1;

   function automatic int clamp_int(int v, int lo, int hi);
      if (v < lo) v = lo;
      if (v > hi) v = hi;
      return v;
   endfunction

   function automatic int axis_step(logic [PIX_W-1:0] pos, logic [PIX_W-1:0] ctr,
                                    logic [GAIN_W-1:0] gain);
      int err;
      int mag;
      int step;
      err = int'(pos) - int'(ctr);
      mag = (err < 0) ? -err : err;
      if (mag <= int'(t_cfg.dead_zone)) return 0;
      step = (int'(gain) * mag) >>> 16;
      if (step > int'(STEP_LIMIT)) step = int'(STEP_LIMIT);
      return (err < 0) ? -step : step;
   endfunction

   function automatic void tracker_step(command_type cmd, logic [PIX_W-1:0] fx,
                                        logic [PIX_W-1:0] fy, longint cyc);
      int lo;
      int hi;
      servo_cmd_t c;
      if (cmd == CMD_TICK) begin
         if (t_elapsed < int'(COUNT_MAX)) t_elapsed++;
         return;
      end
      t_pan  = t_pan + axis_step(fx, t_cfg.center_x, t_cfg.pan_gain);
      t_tilt = t_tilt - axis_step(fy, t_cfg.center_y, t_cfg.tilt_gain);
      lo = int'(t_cfg.angle_min);
      hi = int'(t_cfg.angle_max);
      t_pan  = clamp_int(t_pan, lo, hi);
      t_tilt = clamp_int(t_tilt, lo, hi);
      if ((t_pan != t_last_pan || t_tilt != t_last_tilt || !t_sent)
          && t_elapsed >= int'(t_cfg.send_interval)) begin
         t_pan  = clamp_int(t_pan, t_last_pan - 1, t_last_pan + 1);
         t_tilt = clamp_int(t_tilt, t_last_tilt - 1, t_last_tilt + 1);
         t_elapsed   = 0;
         t_last_pan  = t_pan;
         t_last_tilt = t_tilt;
         t_sent      = 1'b1;
         c.pan  = t_pan[ANGLE_W-1:0];
         c.tilt = t_tilt[ANGLE_W-1:0];
         c.cyc  = cyc;
         owed_cmds.insert(owed_cmds.size(), c);
      end
   endfunction

   // driver: bursts and gaps, with an occasional pause until all results are in
   int gap_left = 0;
   int burst_left = 1;
   int burst_count = 0;
   bit drain_hold = 1'b0;

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall)
            tracker_step(command_type'(req_command), req_face_x, req_face_y, cycle_count);
         if (!req_valid || !req_stall) begin
            if (drain_hold) begin
               req_valid <= 1'b0;
               if (owed_cmds.size() == 0) drain_hold = 1'b0;
            end else if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (req_queue.size() > 0) begin
               track_item_t it;
               it = req_queue.pop_front();
               req_valid   <= 1'b1;
               req_command <= it.cmd;
               req_face_x  <= it.fx;
               req_face_y  <= it.fy;
               burst_left--;
               if (burst_left <= 0) begin
                  burst_count++;
                  burst_left = $urandom_range(1, 40);
                  gap_left = ($urandom % 4 == 0) ? 0 : $urandom_range(1, 12);
                  if (burst_count == 3 || $urandom % 6 == 0) drain_hold = 1'b1;
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // receiver stall pattern
   stall_pattern_t stall_mode = STALL_NONE;
   int stall_left = 0;

   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_mode = stall_pattern_t'($urandom_range(0, 3));
         stall_left = $urandom_range(20, 200);
      end else begin
         stall_left--;
      end
      case (stall_mode)
         STALL_NONE:  rsp_stall <= 1'b0;
         STALL_LIGHT: rsp_stall <= ($urandom % 4 == 0);
         STALL_HEAVY: rsp_stall <= ($urandom % 4 != 0);
         default:     rsp_stall <= ((cycle_count % 7) < 3);
      endcase
   end

   // monitor
   servo_cmd_t got;

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (owed_cmds.size() == 0 || owed_cmds[0].cyc >= cycle_count) begin
            mismatch_count++;
            $display("%0t: unexpected item pan %0d tilt %0d", $time,
                     rsp_pan_out, rsp_tilt_out);
         end else begin
            got = owed_cmds.pop_front();
            if (rsp_pan_out !== got.pan) begin
               mismatch_count++;
               $display("%0t: pan_out expected %0d actual %0d", $time, got.pan, rsp_pan_out);
            end
            if (rsp_tilt_out !== got.tilt) begin
               mismatch_count++;
               $display("%0t: tilt_out expected %0d actual %0d", $time, got.tilt,
                        rsp_tilt_out);
            end
         end
      end
   end

   task automatic write_csr(csr_index_type idx, logic [CSR_DATA_W-1:0] val);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we    <= 1'b0;
      case (idx)
         CSR_DEAD_ZONE:     t_cfg.dead_zone     = val[PIX_W-1:0];
         CSR_PAN_GAIN:      t_cfg.pan_gain      = val[GAIN_W-1:0];
         CSR_TILT_GAIN:     t_cfg.tilt_gain     = val[GAIN_W-1:0];
         CSR_ANGLE_MIN:     t_cfg.angle_min     = val[ANGLE_W-1:0];
         CSR_ANGLE_MAX:     t_cfg.angle_max     = val[ANGLE_W-1:0];
         CSR_CENTER_X:      t_cfg.center_x      = val[PIX_W-1:0];
         CSR_CENTER_Y:      t_cfg.center_y      = val[PIX_W-1:0];
         default:           t_cfg.send_interval = val[COUNT_W-1:0];
      endcase
   endtask

   task automatic apply_cfg(cfg_type c);
      write_csr(CSR_DEAD_ZONE, CSR_DATA_W'(c.dead_zone));
      write_csr(CSR_PAN_GAIN, CSR_DATA_W'(c.pan_gain));
      write_csr(CSR_TILT_GAIN, CSR_DATA_W'(c.tilt_gain));
      write_csr(CSR_ANGLE_MIN, CSR_DATA_W'(c.angle_min));
      write_csr(CSR_ANGLE_MAX, CSR_DATA_W'(c.angle_max));
      write_csr(CSR_CENTER_X, CSR_DATA_W'(c.center_x));
      write_csr(CSR_CENTER_Y, CSR_DATA_W'(c.center_y));
      write_csr(CSR_SEND_INTERVAL, CSR_DATA_W'(c.send_interval));
   endtask

   task automatic push_item(command_type cmd, int fx, int fy);
      track_item_t it;
      it.cmd = cmd;
      it.fx  = fx[PIX_W-1:0];
      it.fy  = fy[PIX_W-1:0];
      req_queue.insert(req_queue.size(), it);
   endtask

   function automatic int near_pos(logic [PIX_W-1:0] ctr);
      int off;
      off = $urandom_range(0, int'(t_cfg.dead_zone) + 60);
      return clamp_int(($urandom % 2) ? int'(ctr) + off : int'(ctr) - off, 0, 4095);
   endfunction

   task automatic queue_random(int n);
      repeat (n) begin
         if ($urandom % 100 < 55)
            push_item(CMD_TICK, $urandom_range(0, 4095), $urandom_range(0, 4095));
         else if ($urandom % 3 == 0)
            push_item(CMD_TARGET, near_pos(t_cfg.center_x), near_pos(t_cfg.center_y));
         else
            push_item(CMD_TARGET, $urandom_range(0, 4095), $urandom_range(0, 4095));
      end
   endtask

   function automatic cfg_type rand_cfg();
      cfg_type c;
      c.dead_zone = ($urandom % 4 == 0) ? PIX_W'($urandom_range(0, 4095))
                                         : PIX_W'($urandom_range(0, 120));
      c.pan_gain  = ($urandom % 2) ? GAIN_W'($urandom_range(0, 65535))
                                   : GAIN_W'($urandom_range(0, 4000));
      c.tilt_gain = ($urandom % 2) ? GAIN_W'($urandom_range(0, 65535))
                                   : GAIN_W'($urandom_range(0, 4000));
      if ($urandom % 5 == 0) begin
         c.angle_min = ANGLE_W'($urandom_range(0, 255));
         c.angle_max = ANGLE_W'($urandom_range(0, 255));
      end else begin
         c.angle_min = ANGLE_W'($urandom_range(0, 90));
         c.angle_max = ANGLE_W'($urandom_range(int'(c.angle_min), 180));
      end
      c.center_x = PIX_W'($urandom_range(0, 4095));
      c.center_y = PIX_W'($urandom_range(0, 4095));
      c.send_interval = ($urandom % 12 == 0) ? COUNT_W'($urandom_range(0, 65535))
                                              : COUNT_W'($urandom_range(0, 25));
      return c;
   endfunction

   task automatic wait_idle();
      while (req_queue.size() > 0 || req_valid || owed_cmds.size() > 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   initial begin
      #(20_000_000);
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin
      cfg_type c;
      t_cfg.dead_zone     = RST_DEAD_ZONE;
      t_cfg.pan_gain      = RST_PAN_GAIN;
      t_cfg.tilt_gain     = RST_TILT_GAIN;
      t_cfg.angle_min     = RST_ANGLE_MIN;
      t_cfg.angle_max     = RST_ANGLE_MAX;
      t_cfg.center_x      = RST_CENTER_X;
      t_cfg.center_y      = RST_CENTER_Y;
      t_cfg.send_interval = RST_SEND_INTERVAL;
      t_pan       = int'(ANGLE_HOME);
      t_tilt      = int'(ANGLE_HOME);
      t_last_pan  = int'(ANGLE_HOME);
      t_last_tilt = int'(ANGLE_HOME);
      t_sent      = 1'b0;
      t_elapsed   = int'(COUNT_MAX);

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings: saturated counter, first send, no send within interval
      push_item(CMD_TICK, 4095, 4095);
      push_item(CMD_TARGET, 640, 360);
      push_item(CMD_TARGET, 4095, 0);
      push_item(CMD_TICK, 0, 0);
      wait_idle();

      // full gain, no dead zone, wide limits above 180, slew toward big steps
      c = '{dead_zone: 12'd0, pan_gain: 16'hFFFF, tilt_gain: 16'hFFFF,
            angle_min: 8'd0, angle_max: 8'd255, center_x: 12'd0, center_y: 12'd4095,
            send_interval: 16'd0};
      apply_cfg(c);
      push_item(CMD_TARGET, 4095, 0);
      push_item(CMD_TARGET, 4095, 0);
      push_item(CMD_TARGET, 0, 4095);
      push_item(CMD_TARGET, 1, 4094);
      push_item(CMD_TARGET, 4095, 4095);
      push_item(CMD_TARGET, 0, 0);
      wait_idle();

      // crossed limits: result pinned to angle_max, slew leaves it outside
      c = '{dead_zone: 12'd4095, pan_gain: 16'd0, tilt_gain: 16'd0,
            angle_min: 8'd150, angle_max: 8'd20, center_x: 12'd4095, center_y: 12'd0,
            send_interval: 16'd0};
      apply_cfg(c);
      push_item(CMD_TARGET, 0, 0);
      push_item(CMD_TARGET, 4095, 4095);
      push_item(CMD_TARGET, 2048, 2048);
      wait_idle();

      // dead zone edge and truncation toward zero
      c = '{dead_zone: 12'd100, pan_gain: 16'd1966, tilt_gain: 16'd1966,
            angle_min: 8'd45, angle_max: 8'd135, center_x: 12'd1000, center_y: 12'd2000,
            send_interval: 16'd2};
      apply_cfg(c);
      push_item(CMD_TARGET, 1100, 1900);
      push_item(CMD_TICK, 0, 0);
      push_item(CMD_TICK, 0, 0);
      push_item(CMD_TARGET, 1101, 1899);
      push_item(CMD_TARGET, 1300, 2300);
      push_item(CMD_TICK, 0, 0);
      push_item(CMD_TICK, 0, 0);
      push_item(CMD_TARGET, 900, 2101);
      wait_idle();

      c = '{dead_zone: 12'd0, pan_gain: 16'hFFFF, tilt_gain: 16'hFFFF,
            angle_min: 8'd0, angle_max: 8'd180, center_x: 12'd2048, center_y: 12'd2048,
            send_interval: 16'hFFFF};
      apply_cfg(c);
      push_item(CMD_TARGET, 0, 4095);
      push_item(CMD_TICK, 0, 0);
      wait_idle();

      repeat (6) begin
         apply_cfg(rand_cfg());
         queue_random(300);
         wait_idle();
      end

      if (mismatch_count == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
